[design/bur_pkg.sv]
package bur_pkg;

	localparam int unsigned CLOCK_HZ = 16000000;
	localparam int unsigned BAUD_SPECIAL = 57600;
	localparam int unsigned CLOCK_SPECIAL = 16000000;
	localparam int unsigned MAX_DEPTH_DEF = 256;
	localparam int unsigned MAX_LOG2_LIMIT = 8;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 21;
	localparam int unsigned BAUD_W = 21;
	localparam int unsigned LG_W = 4;
	localparam int unsigned DIVISOR_W = 12;
	localparam int unsigned OVF_W = 16;

	localparam int unsigned K_DBL_INT = CLOCK_HZ / 4;
	localparam int unsigned K_SGL_INT = CLOCK_HZ / 8;
	localparam int unsigned DIV_W = $clog2(K_DBL_INT + 1);
	localparam logic [DIV_W-1:0] K_DBL = DIV_W'(K_DBL_INT);
	localparam logic [DIV_W-1:0] K_SGL = DIV_W'(K_SGL_INT);
	localparam bit CLOCK_IS_SPECIAL = (CLOCK_HZ == CLOCK_SPECIAL);
	localparam logic [BAUD_W-1:0] BAUD_SPECIAL_V = BAUD_W'(BAUD_SPECIAL);
	localparam logic [DIVISOR_W-1:0] DIVISOR_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_PORT_OPEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NONBLOCKING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RX_SIZE_LOG2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TX_SIZE_LOG2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAUD_RATE = 3'd4;

	localparam logic [BAUD_W-1:0] BAUD_RESET = 21'd57600;
	localparam logic [LG_W-1:0] SIZE_LOG2_RESET = 4'd6;

	localparam logic [2:0] REQ_RX_PUSH = 3'd0;
	localparam logic [2:0] REQ_READ = 3'd1;
	localparam logic [2:0] REQ_PEEK = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_TX_POP = 3'd4;
	localparam logic [2:0] REQ_FLUSH = 3'd5;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_EMPTY = 3'd1;
	localparam logic [2:0] STS_FULL_DROPPED = 3'd2;
	localparam logic [2:0] STS_CLOSED = 3'd3;
	localparam logic [2:0] STS_FULL_RETRY = 3'd4;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [7:0]           read_byte;
		logic [7:0]           rx_count;
		logic [7:0]           tx_space;
		logic [OVF_W-1:0]     overflow_count;
		logic [DIVISOR_W-1:0] baud_divisor;
		logic                 double_speed;
	} rsp_t;

	function automatic int unsigned max_log2(input int unsigned depth);
		int unsigned lg;
		lg = MAX_LOG2_LIMIT;
		while (lg > 1 && (1 << lg) > depth) begin
			lg = lg - 1;
		end
		return lg;
	endfunction

	function automatic logic [7:0] ring_mask(input logic [LG_W-1:0] lg,
		input logic [LG_W-1:0] lg_max);
		logic [LG_W-1:0] e;
		logic [8:0]      one_hot;
		e = lg;
		if (e < 4'd1) begin
			e = 4'd1;
		end
		if (e > 4'd8) begin
			e = 4'd8;
		end
		if (e > lg_max) begin
			e = lg_max;
		end
		one_hot = 9'd1 << e;
		return 8'(one_hot - 9'd1);
	endfunction

endpackage

[design/buffered_uart_ring_port.sv]
// An accepted transaction is registered in stage one, then in the output register.
// Throughput: one transaction per cycle unless the output stalls or the divider runs;
// the rings are synchronous memories read at accept. A bit-serial divider finds the divisor
// after reset and after each baud_rate write, during which no transaction is accepted.
// Reset clears the ring pointers, the overflow count and the registers to their defaults;
// the ring memories are not cleared.
module buffered_uart_ring_port #(
	parameter int unsigned MAX_DEPTH = bur_pkg::MAX_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bur_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bur_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bur_pkg::req_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bur_pkg::rsp_t                     out_data
);

	localparam int unsigned AW = bur_pkg::max_log2(MAX_DEPTH);
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned BI = (bur_pkg::DIV_W > 1) ? $clog2(bur_pkg::DIV_W) : 1;
	localparam logic [bur_pkg::LG_W-1:0] LG_MAX = bur_pkg::LG_W'(AW);

	typedef enum logic [3:0] {
		DS_LOAD = 4'b0001,
		DS_RUN  = 4'b0010,
		DS_DONE = 4'b0100,
		DS_IDLE = 4'b1000
	} div_state_t;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_RX   = 2'd1,
		SEL_TX   = 2'd2
	} rsel_t;

	logic                          port_open_q;
	logic                          nonblocking_q;
	logic [bur_pkg::LG_W-1:0]      rx_lg_q;
	logic [bur_pkg::LG_W-1:0]      tx_lg_q;
	logic [bur_pkg::BAUD_W-1:0]    baud_q;

	logic [7:0]                    rx_mask8;
	logic [7:0]                    tx_mask8;
	logic [AW-1:0]                 rx_mask;
	logic [AW-1:0]                 tx_mask;

	logic [AW-1:0]                 rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [AW-1:0]                 rx_head_n, rx_tail_n, tx_head_n, tx_tail_n;
	logic [AW-1:0]                 rx_nxt, tx_nxt;
	logic [bur_pkg::OVF_W-1:0]     dropped_q, dropped_n;

	logic [7:0]                    rx_mem [DEPTH];
	logic [7:0]                    tx_mem [DEPTH];
	logic [7:0]                    rx_rd_q, tx_rd_q;
	logic                          rx_we, tx_we;

	logic [2:0]                    status_n;
	rsel_t                         rsel_n;
	logic [7:0]                    rx_count_n, tx_space_n;

	logic                          valid_s1;
	logic [2:0]                    status_s1;
	rsel_t                         rsel_s1;
	logic [7:0]                    rx_count_s1, tx_space_s1;
	logic [bur_pkg::OVF_W-1:0]     ovf_s1;

	logic                          out_valid_q;
	bur_pkg::rsp_t                 out_q;
	logic [7:0]                    read_byte_s1;

	div_state_t                    dstate_q;
	logic [bur_pkg::BAUD_W-1:0]    rem_q;
	logic [bur_pkg::DIV_W-1:0]     quo_q;
	logic [BI-1:0]                 bit_q;
	logic                          u2x_q;
	logic [bur_pkg::DIVISOR_W-1:0] div_q;
	logic                          dbl_q;
	logic                          kbit;
	logic [bur_pkg::BAUD_W:0]      rem_sh;
	logic                          rem_ge;
	logic [bur_pkg::DIV_W-1:0]     quo_half;

	logic                          accept;
	logic                          s1_adv;
	logic                          cfg_empties;
	logic                          cfg_baud;

	assign rx_mask8 = bur_pkg::ring_mask(rx_lg_q, LG_MAX);
	assign tx_mask8 = bur_pkg::ring_mask(tx_lg_q, LG_MAX);
	assign rx_mask = rx_mask8[AW-1:0];
	assign tx_mask = tx_mask8[AW-1:0];

	assign s1_adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = (dstate_q == DS_IDLE) && (!valid_s1 || s1_adv);
	assign accept = in_valid && in_ready;

	assign cfg_empties = cfg_we && (cfg_index == bur_pkg::REG_PORT_OPEN
		|| cfg_index == bur_pkg::REG_RX_SIZE_LOG2 || cfg_index == bur_pkg::REG_TX_SIZE_LOG2
		|| cfg_index == bur_pkg::REG_BAUD_RATE);
	assign cfg_baud = cfg_we && (cfg_index == bur_pkg::REG_BAUD_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_open_q <= 1'b1;
			nonblocking_q <= 1'b0;
			rx_lg_q <= bur_pkg::SIZE_LOG2_RESET;
			tx_lg_q <= bur_pkg::SIZE_LOG2_RESET;
			baud_q <= bur_pkg::BAUD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bur_pkg::REG_PORT_OPEN: port_open_q <= cfg_data[0];
				bur_pkg::REG_NONBLOCKING: nonblocking_q <= cfg_data[0];
				bur_pkg::REG_RX_SIZE_LOG2: rx_lg_q <= cfg_data[bur_pkg::LG_W-1:0];
				bur_pkg::REG_TX_SIZE_LOG2: tx_lg_q <= cfg_data[bur_pkg::LG_W-1:0];
				bur_pkg::REG_BAUD_RATE: baud_q <= cfg_data[bur_pkg::BAUD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rx_head_n = rx_head_q;
		rx_tail_n = rx_tail_q;
		tx_head_n = tx_head_q;
		tx_tail_n = tx_tail_q;
		dropped_n = dropped_q;
		status_n = bur_pkg::STS_OK;
		rsel_n = SEL_NONE;
		rx_we = 1'b0;
		tx_we = 1'b0;
		rx_nxt = (rx_head_q + AW'(1)) & rx_mask;
		tx_nxt = (tx_head_q + AW'(1)) & tx_mask;
		if (!port_open_q) begin
			status_n = bur_pkg::STS_CLOSED;
		end else begin
			unique case (in_data.req_type)
				bur_pkg::REQ_RX_PUSH: begin
					if (rx_nxt == rx_tail_q) begin
						status_n = bur_pkg::STS_FULL_DROPPED;
						if (dropped_q != '1) begin
							dropped_n = dropped_q + bur_pkg::OVF_W'(1);
						end
					end else begin
						rx_we = 1'b1;
						rx_head_n = rx_nxt;
					end
				end
				bur_pkg::REQ_READ, bur_pkg::REQ_PEEK: begin
					if (rx_head_q == rx_tail_q) begin
						status_n = bur_pkg::STS_EMPTY;
					end else begin
						rsel_n = SEL_RX;
						if (in_data.req_type == bur_pkg::REQ_READ) begin
							rx_tail_n = (rx_tail_q + AW'(1)) & rx_mask;
						end
					end
				end
				bur_pkg::REQ_WRITE: begin
					if (tx_nxt == tx_tail_q) begin
						status_n = nonblocking_q ? bur_pkg::STS_FULL_DROPPED
							: bur_pkg::STS_FULL_RETRY;
					end else begin
						tx_we = 1'b1;
						tx_head_n = tx_nxt;
					end
				end
				bur_pkg::REQ_TX_POP: begin
					if (tx_head_q == tx_tail_q) begin
						status_n = bur_pkg::STS_EMPTY;
					end else begin
						rsel_n = SEL_TX;
						tx_tail_n = (tx_tail_q + AW'(1)) & tx_mask;
					end
				end
				bur_pkg::REQ_FLUSH: begin
					rx_head_n = rx_tail_q;
					tx_tail_n = tx_head_q;
				end
				default: ;
			endcase
		end
		rx_count_n = 8'((rx_head_n - rx_tail_n) & rx_mask);
		tx_space_n = 8'(tx_mask - ((tx_head_n - tx_tail_n) & tx_mask));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			dropped_q <= '0;
		end else if (cfg_empties) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
		end else if (accept) begin
			rx_head_q <= rx_head_n;
			rx_tail_q <= rx_tail_n;
			tx_head_q <= tx_head_n;
			tx_tail_q <= tx_tail_n;
			dropped_q <= dropped_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && rx_we) begin
			rx_mem[rx_head_q] <= in_data.data_byte;
		end
		if (accept) begin
			rx_rd_q <= rx_mem[rx_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && tx_we) begin
			tx_mem[tx_head_q] <= in_data.data_byte;
		end
		if (accept) begin
			tx_rd_q <= tx_mem[tx_tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_n;
			rsel_s1 <= rsel_n;
			rx_count_s1 <= port_open_q ? rx_count_n : 8'd0;
			tx_space_s1 <= port_open_q ? tx_space_n : 8'd0;
			ovf_s1 <= port_open_q ? dropped_n : '0;
		end
	end

	always_comb begin
		unique case (rsel_s1)
			SEL_RX: read_byte_s1 = rx_rd_q;
			SEL_TX: read_byte_s1 = tx_rd_q;
			default: read_byte_s1 = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.status <= status_s1;
			out_q.read_byte <= read_byte_s1;
			out_q.rx_count <= rx_count_s1;
			out_q.tx_space <= tx_space_s1;
			out_q.overflow_count <= ovf_s1;
			out_q.baud_divisor <= div_q;
			out_q.double_speed <= dbl_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign kbit = u2x_q ? bur_pkg::K_DBL[bit_q] : bur_pkg::K_SGL[bit_q];
	assign rem_sh = {rem_q, kbit};
	assign rem_ge = rem_sh >= {1'b0, baud_q};
	assign quo_half = (quo_q - bur_pkg::DIV_W'(1)) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= DS_LOAD;
		end else if (cfg_baud) begin
			dstate_q <= DS_LOAD;
		end else begin
			unique case (dstate_q)
				DS_LOAD: dstate_q <= DS_RUN;
				DS_RUN: begin
					if (bit_q == '0) begin
						dstate_q <= DS_DONE;
					end
				end
				DS_DONE: dstate_q <= DS_IDLE;
				DS_IDLE: dstate_q <= DS_IDLE;
				default: dstate_q <= DS_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (dstate_q)
			DS_LOAD: begin
				rem_q <= '0;
				quo_q <= '0;
				bit_q <= BI'(bur_pkg::DIV_W - 1);
				u2x_q <= !(bur_pkg::CLOCK_IS_SPECIAL && baud_q == bur_pkg::BAUD_SPECIAL_V);
			end
			DS_RUN: begin
				rem_q <= rem_ge ? bur_pkg::BAUD_W'(rem_sh - {1'b0, baud_q})
					: rem_sh[bur_pkg::BAUD_W-1:0];
				quo_q <= {quo_q[bur_pkg::DIV_W-2:0], rem_ge};
				bit_q <= bit_q - BI'(1);
			end
			DS_DONE: begin
				if (baud_q == '0) begin
					div_q <= bur_pkg::DIVISOR_MAX;
					dbl_q <= 1'b1;
				end else begin
					dbl_q <= u2x_q;
					if (quo_q == '0) begin
						div_q <= '0;
					end else if (quo_half > bur_pkg::DIV_W'(bur_pkg::DIVISOR_MAX)) begin
						div_q <= bur_pkg::DIVISOR_MAX;
					end else begin
						div_q <= quo_half[bur_pkg::DIVISOR_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_rx_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		((rx_head_q & ~rx_mask) == '0) && ((rx_tail_q & ~rx_mask) == '0))
		else $error("receive pointer outside the ring");

	a_tx_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		((tx_head_q & ~tx_mask) == '0) && ((tx_tail_q & ~tx_mask) == '0))
		else $error("transmit pointer outside the ring");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready ##1 valid_s1)
		else $error("stage one lost a transaction while the output stalled");

	a_dropped_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> dropped_q >= $past(dropped_q))
		else $error("overflow count decreased");

	a_baud_restarts_divider: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_baud |=> dstate_q == DS_LOAD && !in_ready)
		else $error("baud write did not restart the divisor computation");
`endif

endmodule

[tb/buffered_uart_ring_port_tb.sv]
`timescale 1ns / 100ps

module buffered_uart_ring_port_tb;

	localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [2:0] REQ_UNUSED_7 = 3'd7;
	localparam logic [bur_pkg::CFG_IDX_W-1:0] REG_NONE_5 = 3'd5;
	localparam logic [bur_pkg::CFG_IDX_W-1:0] REG_NONE_6 = 3'd6;
	localparam logic [bur_pkg::CFG_IDX_W-1:0] REG_NONE_7 = 3'd7;

	typedef enum int {FILL, MIXED, EMPTYING} traffic_t;

	class ring_port_shadow;
		logic [7:0]  rx_ring [256];
		logic [7:0]  tx_ring [256];
		logic [7:0]  rx_wr, rx_rd, tx_wr, tx_rd;
		logic [15:0] drops;
		bit          is_open, drop_full_writes;
		logic [3:0]  rx_lg, tx_lg;
		logic [20:0] baud;
		bur_pkg::rsp_t due [$];
		int          errors;

		function new();
			empty_rings();
			drops = '0;
			is_open = 1'b1;
			drop_full_writes = 1'b0;
			rx_lg = bur_pkg::SIZE_LOG2_RESET;
			tx_lg = bur_pkg::SIZE_LOG2_RESET;
			baud = bur_pkg::BAUD_RESET;
			errors = 0;
		endfunction

		function void empty_rings();
			rx_wr = '0;
			rx_rd = '0;
			tx_wr = '0;
			tx_rd = '0;
		endfunction

		function void write_reg(logic [bur_pkg::CFG_IDX_W-1:0] idx,
			logic [bur_pkg::CFG_DATA_W-1:0] value);
			case (idx)
			bur_pkg::REG_PORT_OPEN: begin
				is_open = value[0];
				empty_rings();
			end
			bur_pkg::REG_NONBLOCKING: begin
				drop_full_writes = value[0];
			end
			bur_pkg::REG_RX_SIZE_LOG2: begin
				rx_lg = value[3:0];
				empty_rings();
			end
			bur_pkg::REG_TX_SIZE_LOG2: begin
				tx_lg = value[3:0];
				empty_rings();
			end
			bur_pkg::REG_BAUD_RATE: begin
				baud = value;
				empty_rings();
			end
			default: ;
			endcase
		endfunction

		function logic [7:0] size_mask(logic [3:0] lg);
			int unsigned e;
			e = lg;
			if (e < 1)
				e = 1;
			if (e > 8)
				e = 8;
			while (e > 1 && (1 << e) > bur_pkg::MAX_DEPTH_DEF)
				e--;
			return 8'((1 << e) - 1);
		endfunction

		function void line_divisor(output logic [11:0] div, output logic dbl);
			longint unsigned q, v;
			bit fast;
			if (baud == 0) begin
				div = '1;
				dbl = 1'b1;
				return;
			end
			fast = !(bur_pkg::CLOCK_HZ == bur_pkg::CLOCK_SPECIAL
				&& baud == bur_pkg::BAUD_SPECIAL);
			if (fast)
				q = longint'(bur_pkg::CLOCK_HZ) / 4 / longint'(baud);
			else
				q = longint'(bur_pkg::CLOCK_HZ) / 8 / longint'(baud);
			v = (q == 0) ? 0 : (q - 1) / 2;
			if (v > 4095)
				v = 4095;
			div = v[11:0];
			dbl = fast;
		endfunction

		function bur_pkg::rsp_t serve_request(bur_pkg::req_t r);
			bur_pkg::rsp_t rsp;
			logic [7:0] rm, tm, nxt;
			logic [11:0] div;
			logic       dbl;
			rm = size_mask(rx_lg);
			tm = size_mask(tx_lg);
			rsp = '0;
			line_divisor(div, dbl);
			rsp.baud_divisor = div;
			rsp.double_speed = dbl;
			if (!is_open) begin
				rsp.status = bur_pkg::STS_CLOSED;
				return rsp;
			end
			rsp.status = bur_pkg::STS_OK;
			case (r.req_type)
			bur_pkg::REQ_RX_PUSH: begin
				nxt = (rx_wr + 8'd1) & rm;
				if (nxt == (rx_rd & rm)) begin
					rsp.status = bur_pkg::STS_FULL_DROPPED;
					if (drops != 16'hFFFF)
						drops++;
				end else begin
					rx_ring[rx_wr & rm] = r.data_byte;
					rx_wr = nxt;
				end
			end
			bur_pkg::REQ_READ, bur_pkg::REQ_PEEK: begin
				if ((rx_wr & rm) == (rx_rd & rm)) begin
					rsp.status = bur_pkg::STS_EMPTY;
				end else begin
					rsp.read_byte = rx_ring[rx_rd & rm];
					if (r.req_type == bur_pkg::REQ_READ)
						rx_rd = (rx_rd + 8'd1) & rm;
				end
			end
			bur_pkg::REQ_WRITE: begin
				nxt = (tx_wr + 8'd1) & tm;
				if (nxt == (tx_rd & tm)) begin
					rsp.status = drop_full_writes ? bur_pkg::STS_FULL_DROPPED
						: bur_pkg::STS_FULL_RETRY;
				end else begin
					tx_ring[tx_wr & tm] = r.data_byte;
					tx_wr = nxt;
				end
			end
			bur_pkg::REQ_TX_POP: begin
				if ((tx_wr & tm) == (tx_rd & tm)) begin
					rsp.status = bur_pkg::STS_EMPTY;
				end else begin
					rsp.read_byte = tx_ring[tx_rd & tm];
					tx_rd = (tx_rd + 8'd1) & tm;
				end
			end
			bur_pkg::REQ_FLUSH: begin
				rx_wr = rx_rd;
				tx_rd = tx_wr;
			end
			default: ;
			endcase
			rsp.rx_count = (rx_wr - rx_rd) & rm;
			rsp.tx_space = tm - ((tx_wr - tx_rd) & tm);
			rsp.overflow_count = drops;
			return rsp;
		endfunction

		function void note_request(bur_pkg::req_t r);
			due.push_back(serve_request(r));
		endfunction

		function string show(bur_pkg::rsp_t r);
			return $sformatf("status=%0d byte=%02h rx=%0d tx=%0d ovf=%0d div=%0d dbl=%0d",
				r.status, r.read_byte, r.rx_count, r.tx_space, r.overflow_count,
				r.baud_divisor, r.double_speed);
		endfunction

		function void check_response(bur_pkg::rsp_t got);
			bur_pkg::rsp_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: response with none pending: %s", $time, show(got));
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status || got.read_byte !== want.read_byte ||
				got.rx_count !== want.rx_count || got.tx_space !== want.tx_space ||
				got.overflow_count !== want.overflow_count ||
				got.baud_divisor !== want.baud_divisor ||
				got.double_speed !== want.double_speed) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch, expected %s, got %s", $time, show(want), show(got));
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [bur_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bur_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	bur_pkg::req_t         in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	bur_pkg::rsp_t         out_data;
	bit                    tx_gaps_on = 1'b1;
	bit                    rx_stalls_on = 1'b1;

	ring_port_shadow shadow = new();

	buffered_uart_ring_port DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				shadow.check_response(out_data);
			if (cfg_we)
				shadow.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				shadow.note_request(in_data);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic bur_pkg::req_t mk(logic [2:0] op, logic [7:0] b);
		bur_pkg::req_t r;
		r.req_type = op;
		r.data_byte = b;
		return r;
	endfunction

	function automatic bur_pkg::req_t random_request(traffic_t mode);
		int t [6];
		int pick;
		logic [2:0] op;
		case (mode)
		FILL: t = '{30, 60, 72, 80, 93, 97};
		MIXED: t = '{20, 40, 58, 68, 88, 96};
		default: t = '{12, 24, 50, 62, 90, 96};
		endcase
		pick = $urandom_range(0, 99);
		if (pick < t[0])
			op = bur_pkg::REQ_RX_PUSH;
		else if (pick < t[1])
			op = bur_pkg::REQ_WRITE;
		else if (pick < t[2])
			op = bur_pkg::REQ_READ;
		else if (pick < t[3])
			op = bur_pkg::REQ_PEEK;
		else if (pick < t[4])
			op = bur_pkg::REQ_TX_POP;
		else if (pick < t[5])
			op = bur_pkg::REQ_FLUSH;
		else
			op = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
		return mk(op, 8'($urandom_range(0, 255)));
	endfunction

	function automatic logic [3:0] pick_log2();
		if ($urandom_range(0, 9) < 7)
			return 4'($urandom_range(1, 4));
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [20:0] pick_baud();
		case ($urandom_range(0, 9))
		0: return 21'd0;
		1: return 21'd1;
		2: return 21'd300;
		3: return 21'd2000000;
		4: return 21'h1FFFFF;
		5, 6: return 21'd57600;
		7: return 21'd115200;
		default: return 21'($urandom_range(300, 2000000));
		endcase
	endfunction

	// A transaction is held until accepted; valid drops only when a gap follows.
	task automatic send(bur_pkg::req_t r);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic poke_reg(logic [bur_pkg::CFG_IDX_W-1:0] idx,
		logic [bur_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic end_reg_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int       on_len, off_len;
		forever begin
			on_len = $urandom_range(1, 12);
			@(negedge clk);
			out_ready <= 1'b1;
			repeat (on_len - 1) @(negedge clk);
			off_len = rx_stalls_on ? pick_gap() : 0;
			if (off_len > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (off_len - 1) @(negedge clk);
			end
		end
	end

	initial begin
		int       done_items, phase_len, i;
		bit       open_v;
		traffic_t mode;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(mk(bur_pkg::REQ_PEEK, 8'h00));
		send(mk(bur_pkg::REQ_READ, 8'h00));
		send(mk(bur_pkg::REQ_TX_POP, 8'h00));
		send(mk(bur_pkg::REQ_RX_PUSH, 8'h00));
		send(mk(bur_pkg::REQ_RX_PUSH, 8'hFF));
		send(mk(bur_pkg::REQ_PEEK, 8'h00));
		send(mk(bur_pkg::REQ_READ, 8'h00));
		send(mk(bur_pkg::REQ_READ, 8'h00));
		send(mk(bur_pkg::REQ_READ, 8'h00));
		send(mk(bur_pkg::REQ_WRITE, 8'hFF));
		send(mk(bur_pkg::REQ_WRITE, 8'h00));
		send(mk(bur_pkg::REQ_TX_POP, 8'h00));
		send(mk(REQ_UNUSED_6, 8'hAA));
		send(mk(REQ_UNUSED_7, 8'h55));
		send(mk(bur_pkg::REQ_RX_PUSH, 8'h5A));
		send(mk(bur_pkg::REQ_WRITE, 8'hA5));
		send(mk(bur_pkg::REQ_FLUSH, 8'hFF));
		send(mk(bur_pkg::REQ_READ, 8'h00));
		send(mk(bur_pkg::REQ_TX_POP, 8'h00));
		drain();

		// Smallest rings hold a single byte, so the second push or write hits full.
		poke_reg(bur_pkg::REG_RX_SIZE_LOG2, 21'd1);
		poke_reg(bur_pkg::REG_TX_SIZE_LOG2, 21'd1);
		poke_reg(REG_NONE_5, 21'h1FFFFF);
		poke_reg(REG_NONE_6, 21'h0AAAAA);
		poke_reg(REG_NONE_7, 21'h155555);
		end_reg_writes();
		send(mk(bur_pkg::REQ_RX_PUSH, 8'h11));
		send(mk(bur_pkg::REQ_RX_PUSH, 8'h22));
		send(mk(bur_pkg::REQ_WRITE, 8'h33));
		send(mk(bur_pkg::REQ_WRITE, 8'h44));
		drain();
		poke_reg(bur_pkg::REG_NONBLOCKING, 21'd1);
		end_reg_writes();
		send(mk(bur_pkg::REQ_WRITE, 8'h55));
		drain();
		poke_reg(bur_pkg::REG_PORT_OPEN, 21'd0);
		end_reg_writes();
		send(mk(bur_pkg::REQ_RX_PUSH, 8'h66));
		send(mk(bur_pkg::REQ_READ, 8'h00));
		drain();
		poke_reg(bur_pkg::REG_PORT_OPEN, 21'd1);
		end_reg_writes();

		done_items = 0;
		while (done_items < 550) begin
			drain();
			open_v = ($urandom_range(0, 9) != 0);
			if (open_v != shadow.is_open || $urandom_range(0, 1))
				poke_reg(bur_pkg::REG_PORT_OPEN, 21'(($urandom() << 1) | open_v));
			if ($urandom_range(0, 1))
				poke_reg(bur_pkg::REG_NONBLOCKING,
					21'(($urandom() << 1) | $urandom_range(0, 1)));
			if ($urandom_range(0, 1))
				poke_reg(bur_pkg::REG_RX_SIZE_LOG2, 21'(($urandom() << 4) | pick_log2()));
			if ($urandom_range(0, 1))
				poke_reg(bur_pkg::REG_TX_SIZE_LOG2, 21'(($urandom() << 4) | pick_log2()));
			if ($urandom_range(0, 2) == 0)
				poke_reg(bur_pkg::REG_BAUD_RATE, pick_baud());
			end_reg_writes();
			mode = traffic_t'($urandom_range(0, 2));
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_stalls_on = ($urandom_range(0, 3) != 0);
			phase_len = open_v ? $urandom_range(20, 60) : 6;
			for (i = 0; i < phase_len; i++) begin
				if ($urandom_range(0, 49) == 0)
					drain();
				send(random_request(mode));
			end
			if (open_v)
				done_items += phase_len;
		end

		drain();
		repeat (10) @(posedge clk);
		if (shadow.errors == 0 && shadow.due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
